### sv/cfp_pkg.sv
// Shared types and codes for the command frame parser.
package cfp_pkg;

	// Parser states
	typedef enum logic [3:0] {
		ST_HUNT,
		ST_TYPE,
		ST_HDR_END,
		ST_MODE,
		ST_THROTTLE,
		ST_ROLL,
		ST_PITCH,
		ST_YAW,
		ST_CLOSE
	} parse_state_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_FRAME_BYTE,
		REG_GET_COMMANDS,
		REG_GET_PERIODIC,
		REG_SEND_COMMANDS,
		REG_MODE_MANUAL,
		REG_MODE_AUGMENTED,
		REG_MODE_AUTOPILOT
	} cfg_index_t;

	// Event kinds on the result channel
	localparam logic [1:0] EV_GET_COMMANDS = 2'd0;
	localparam logic [1:0] EV_GET_PERIODIC = 2'd1;
	localparam logic [1:0] EV_CMD_SET      = 2'd2;

	// Reset values of the configuration registers
	localparam logic [7:0] RST_FRAME_BYTE     = 8'd126;
	localparam logic [7:0] RST_GET_COMMANDS   = 8'd1;
	localparam logic [7:0] RST_GET_PERIODIC   = 8'd2;
	localparam logic [7:0] RST_SEND_COMMANDS  = 8'd3;
	localparam logic [7:0] RST_MODE_MANUAL    = 8'd0;
	localparam logic [7:0] RST_MODE_AUGMENTED = 8'd1;
	localparam logic [7:0] RST_MODE_AUTOPILOT = 8'd2;

	// Type byte held after a dropped header
	localparam logic [7:0] NO_TYPE = 8'hFF;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic [7:0] get_commands_code;
		logic [7:0] get_periodic_code;
		logic [7:0] send_commands_code;
		logic [7:0] mode_code_manual;
		logic [7:0] mode_code_augmented;
		logic [7:0] mode_code_autopilot;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        event_kind;
		logic [7:0]        flight_mode;
		logic signed [7:0] throttle_cmd;
		logic signed [7:0] roll_cmd;
		logic signed [7:0] pitch_cmd;
		logic signed [7:0] yaw_cmd;
		logic [31:0]       command_time;
	} result_t;

endpackage

### sv/cfp_cfg_regs.sv
// Configuration register file of the command frame parser.
module cfp_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	output cfp_pkg::cfg_t cfg
);
	import cfp_pkg::*;

	cfg_t cfg_q;

	// Indexed writes; index beyond the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_byte          <= RST_FRAME_BYTE;
			cfg_q.get_commands_code   <= RST_GET_COMMANDS;
			cfg_q.get_periodic_code   <= RST_GET_PERIODIC;
			cfg_q.send_commands_code  <= RST_SEND_COMMANDS;
			cfg_q.mode_code_manual    <= RST_MODE_MANUAL;
			cfg_q.mode_code_augmented <= RST_MODE_AUGMENTED;
			cfg_q.mode_code_autopilot <= RST_MODE_AUTOPILOT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_BYTE:     cfg_q.frame_byte          <= cfg_data;
				REG_GET_COMMANDS:   cfg_q.get_commands_code   <= cfg_data;
				REG_GET_PERIODIC:   cfg_q.get_periodic_code   <= cfg_data;
				REG_SEND_COMMANDS:  cfg_q.send_commands_code  <= cfg_data;
				REG_MODE_MANUAL:    cfg_q.mode_code_manual    <= cfg_data;
				REG_MODE_AUGMENTED: cfg_q.mode_code_augmented <= cfg_data;
				REG_MODE_AUTOPILOT: cfg_q.mode_code_autopilot <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/cfp_parser.sv
// Frame parser state machine with held command fields.
module cfp_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  cfp_pkg::cfg_t    cfg,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	input  logic [31:0]      arrival_time,
	output logic             res_valid,
	output cfp_pkg::result_t res
);
	import cfp_pkg::*;

	parse_state_t state_q, state_d;
	logic [7:0]   type_q, type_d;
	logic [7:0]   mode_q, mode_d;
	logic [7:0]   thr_q, thr_d;
	logic [7:0]   roll_q, roll_d;
	logic [7:0]   pitch_q, pitch_d;
	logic [7:0]   yaw_q, yaw_d;

	logic is_frame, is_type, is_mode;

	assign is_frame = (rx_byte == cfg.frame_byte);
	assign is_type  = (rx_byte == cfg.get_commands_code) ||
	                  (rx_byte == cfg.get_periodic_code) ||
	                  (rx_byte == cfg.send_commands_code);
	assign is_mode  = (rx_byte == cfg.mode_code_manual) ||
	                  (rx_byte == cfg.mode_code_augmented) ||
	                  (rx_byte == cfg.mode_code_autopilot);

	// State registers, updated once per consumed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			type_q  <= NO_TYPE;
			mode_q  <= RST_MODE_MANUAL;
			thr_q   <= '0;
			roll_q  <= '0;
			pitch_q <= '0;
			yaw_q   <= '0;
		end else if (step) begin
			state_q <= state_d;
			type_q  <= type_d;
			mode_q  <= mode_d;
			thr_q   <= thr_d;
			roll_q  <= roll_d;
			pitch_q <= pitch_d;
			yaw_q   <= yaw_d;
		end
	end

	// Next state and result for the beat in the input register
	always_comb begin
		state_d   = ST_HUNT;
		type_d    = type_q;
		mode_d    = mode_q;
		thr_d     = thr_q;
		roll_d    = roll_q;
		pitch_d   = pitch_q;
		yaw_d     = yaw_q;
		res_valid = 1'b0;
		res       = '0;
		case (state_q)
			ST_HUNT: begin
				if (is_frame) state_d = ST_TYPE;
			end
			ST_TYPE: begin
				if (is_type) begin
					type_d  = rx_byte;
					state_d = ST_HDR_END;
				end
			end
			ST_HDR_END: begin
				if (is_frame) begin
					if (type_q == cfg.get_commands_code) begin
						res_valid      = 1'b1;
						res.event_kind = EV_GET_COMMANDS;
					end else if (type_q == cfg.get_periodic_code) begin
						res_valid      = 1'b1;
						res.event_kind = EV_GET_PERIODIC;
					end else if (type_q == cfg.send_commands_code) begin
						state_d = ST_MODE;
					end
				end else begin
					type_d = NO_TYPE;
				end
			end
			ST_MODE: begin
				if (is_mode) begin
					mode_d  = rx_byte;
					state_d = ST_THROTTLE;
				end
			end
			ST_THROTTLE: begin
				thr_d   = rx_byte;
				state_d = ST_ROLL;
			end
			ST_ROLL: begin
				roll_d  = rx_byte;
				state_d = ST_PITCH;
			end
			ST_PITCH: begin
				pitch_d = rx_byte;
				state_d = ST_YAW;
			end
			ST_YAW: begin
				yaw_d   = rx_byte;
				state_d = ST_CLOSE;
			end
			ST_CLOSE: begin
				// closing byte never opens a new frame
				if (is_frame) begin
					res_valid        = 1'b1;
					res.event_kind   = EV_CMD_SET;
					res.flight_mode  = mode_q;
					res.throttle_cmd = thr_q;
					res.roll_cmd     = roll_q;
					res.pitch_cmd    = pitch_q;
					res.yaw_cmd      = yaw_q;
					res.command_time = arrival_time;
				end
			end
			default: state_d = ST_HUNT;
		endcase
	end

	// Results come only from a header close or a frame close
	a_res_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (state_q == ST_HDR_END || state_q == ST_CLOSE))
		else $error("result outside a closing state");

	// Command bytes walk the states in order
	a_yaw_close: assert property (@(posedge clk) disable iff (!arst_n)
		(step && state_q == ST_YAW) |=> state_q == ST_CLOSE)
		else $error("yaw byte not followed by close state");

	// Request events carry zero payload
	a_req_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.event_kind != EV_CMD_SET) |->
		(res.command_time == '0 && res.flight_mode == '0))
		else $error("request event with nonzero payload");

endmodule

### sv/command_frame_parser_top.sv
// Top level of the command frame parser: input register, parser, result register.
// The parser takes one received byte with its timestamp per beat and gives at most
// one event per byte: a commands or periodic request when a header closes, or a
// command set (mode, throttle, roll, pitch, yaw, closing timestamp) when a
// send-commands frame closes. A beat lands in an input register, the frame state
// machine works on it combinationally and the event goes to an output register,
// so the block takes one byte every cycle while in_stall is low. in_stall rises
// only while the input register is full and the output register holds an event
// that is stalled.
// Configuration writes (cfg_we, cfg_index, cfg_data) are applied at once and are
// meant for times when no byte is in flight; indexes above six are ignored.
module command_frame_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic [31:0]        arrival_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         event_kind,
	output logic [7:0]         flight_mode,
	output logic signed [7:0]  throttle_cmd,
	output logic signed [7:0]  roll_cmd,
	output logic signed [7:0]  pitch_cmd,
	output logic signed [7:0]  yaw_cmd,
	output logic [31:0]        command_time
);
	import cfp_pkg::*;

	cfg_t        cfg;
	logic        s1_valid_q;
	logic [7:0]  byte_s1;
	logic [31:0] time_s1;
	logic        out_valid_q;
	result_t     res_q;
	result_t     res;
	logic        res_valid;
	logic        advance;
	logic        step;

	cfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake: output register free or draining this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign step     = s1_valid_q && advance;
	assign in_stall = s1_valid_q && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
			time_s1 <= arrival_time;
		end
	end

	cfp_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.step         (step),
		.rx_byte      (byte_s1),
		.arrival_time (time_s1),
		.res_valid    (res_valid),
		.res          (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = res_q.event_kind;
	assign flight_mode  = res_q.flight_mode;
	assign throttle_cmd = res_q.throttle_cmd;
	assign roll_cmd     = res_q.roll_cmd;
	assign pitch_cmd    = res_q.pitch_cmd;
	assign yaw_cmd      = res_q.yaw_cmd;
	assign command_time = res_q.command_time;

	// Stall only with a beat waiting and a held event blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q && out_stall))
		else $error("input stalled without a blocked event");

	// A held beat with no stalled event is consumed
	a_step_free: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !out_valid_q) |-> step)
		else $error("beat not consumed with output free");

	// A new event appears only after a consumed beat
	a_event_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step && res_valid))
		else $error("event without a consumed beat");

endmodule
